// File: src/reversible_deque_defines.svh
// Assertion macros shared by the deque RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH

`ifndef SYNTH
`define RDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");
`define RDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");
`else
`define RDQ_ASSERT_IMP(lbl, ante, cons)
`define RDQ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: src/rdq_pkg.sv
// Shared types, codes and defaults of the reversible deque.
// No dependencies.
package rdq_pkg;

  localparam int RDQ_DEPTH    = 64;
  localparam int RDQ_CQ_DEPTH = 2;
  localparam int RDQ_OQ_DEPTH = 4;

  // operation codes on the input channel
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REVERSE    = 3'd4;
  localparam logic [2:0] OP_FRONT      = 3'd5;
  localparam logic [2:0] OP_BACK       = 3'd6;
  localparam logic [2:0] OP_PRINT      = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command kinds handed from front to back
  localparam logic [2:0] K_PUSH  = 3'd0;
  localparam logic [2:0] K_POP   = 3'd1;
  localparam logic [2:0] K_REV   = 3'd2;
  localparam logic [2:0] K_PEEK  = 3'd3;
  localparam logic [2:0] K_PRINT = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } rdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } rdq_out_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               logical_front;
    logic signed [31:0] value;
  } rdq_cmd_t;

  typedef struct packed {
    logic     vld;
    rdq_out_t item;
  } rdq_res_t;

endpackage

// File: src/rdq_front.sv
// Front end: accepts operations, classifies them into commands, queues them.
// Depends on rdq_pkg.
module rdq_front #(
  parameter int CQ_DEPTH = rdq_pkg::RDQ_CQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  rdq_pkg::rdq_in_t in_item,
  output logic             cmd_vld,
  output rdq_pkg::rdq_cmd_t cmd,
  input  logic             cmd_pop
);
  import rdq_pkg::*;

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CW = $clog2(CQ_DEPTH + 1);
  localparam logic [CW-1:0] FULL_C = CW'(CQ_DEPTH);
  localparam logic [PW-1:0] LAST_P = PW'(CQ_DEPTH - 1);

  rdq_cmd_t        q_r [CQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  rdq_cmd_t        dec;
  logic            wr_en, rd_en;

  // classify the operation
  always_comb begin
    dec.value         = in_item.value;
    dec.logical_front = 1'b0;
    unique case (in_item.op)
      OP_PUSH_FRONT: begin dec.kind = K_PUSH;  dec.logical_front = 1'b1; end
      OP_PUSH_BACK:  begin dec.kind = K_PUSH;  end
      OP_POP_FRONT:  begin dec.kind = K_POP;   dec.logical_front = 1'b1; end
      OP_POP_BACK:   begin dec.kind = K_POP;   end
      OP_REVERSE:    begin dec.kind = K_REV;   end
      OP_FRONT:      begin dec.kind = K_PEEK;  dec.logical_front = 1'b1; end
      OP_BACK:       begin dec.kind = K_PEEK;  end
      default:       begin dec.kind = K_PRINT; end
    endcase
  end

  assign in_full = (cnt_r == FULL_C);
  assign wr_en   = in_push && !in_full;
  assign cmd_vld = (cnt_r != '0);
  assign rd_en   = cmd_pop && cmd_vld;
  assign cmd     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? ((wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ((rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: src/rdq_back.sv
// Back end: ring store, head/count/reverse state, print walker, result stage.
// Depends on rdq_pkg.
module rdq_back #(
  parameter int DEPTH    = rdq_pkg::RDQ_DEPTH,
  parameter int OQ_DEPTH = rdq_pkg::RDQ_OQ_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_vld,
  input  rdq_pkg::rdq_cmd_t               cmd,
  output logic                            cmd_pop,
  input  logic [$clog2(OQ_DEPTH+1)-1:0]   oq_count,
  output rdq_pkg::rdq_res_t               res
);
  import rdq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int QCW = $clog2(OQ_DEPTH + 1);
  localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0]  LAST_A  = AW'(DEPTH - 1);
  localparam logic [QCW:0]   OQ_C    = (QCW + 1)'(OQ_DEPTH);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PRINT = 1'b1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  logic          state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          flag_r, flag_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          res_vld_r, res_vld_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          res_last_r, res_last_nxt;
  logic          res_mem_r, res_mem_nxt;

  logic          wr_en, rd_en, can_emit, phys_front, is_full, is_empty;
  logic [AW-1:0] wr_addr, rd_addr, head_dec, head_inc;
  logic [CW-1:0] walk_off, last_idx;

  // physical slot of an offset from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign can_emit   = ((QCW + 1)'(oq_count) + (QCW + 1)'(res_vld_r)) < OQ_C;
  assign phys_front = cmd.logical_front ^ flag_r;
  assign is_full    = (count_r == DEPTH_C);
  assign is_empty   = (count_r == '0);
  assign head_dec   = (head_r == '0) ? LAST_A : head_r - 1'b1;
  assign head_inc   = (head_r == LAST_A) ? '0 : head_r + 1'b1;
  assign last_idx   = count_r - 1'b1;
  assign walk_off   = flag_r ? (last_idx - idx_r) : idx_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    flag_nxt       = flag_r;
    idx_nxt        = idx_r;
    res_vld_nxt    = 1'b0;
    res_status_nxt = ST_OK;
    res_last_nxt   = 1'b1;
    res_mem_nxt    = 1'b0;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    rd_en          = 1'b0;
    rd_addr        = slot(head_r, walk_off);
    unique case (state_r)
      S_IDLE: begin
        if (cmd_vld && can_emit) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            K_PUSH: begin
              if (is_full) begin
                res_vld_nxt    = 1'b1;
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (phys_front) begin
                  head_nxt = head_dec;
                  wr_addr  = head_dec;
                end else begin
                  wr_addr = slot(head_r, count_r);
                end
              end
            end
            K_POP: begin
              if (is_empty) begin
                res_vld_nxt    = 1'b1;
                res_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                if (phys_front) begin
                  head_nxt = head_inc;
                end
              end
            end
            K_REV: begin
              flag_nxt = !flag_r;
            end
            K_PEEK: begin
              res_vld_nxt = 1'b1;
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en       = 1'b1;
                res_mem_nxt = 1'b1;
                rd_addr     = phys_front ? head_r : slot(head_r, last_idx);
              end
            end
            K_PRINT: begin
              res_vld_nxt = 1'b1;
              if (is_empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                // first entry; idx_r is zero whenever idle
                rd_en        = 1'b1;
                res_mem_nxt  = 1'b1;
                res_last_nxt = (last_idx == '0);
                if (last_idx != '0) begin
                  cmd_pop   = 1'b0;
                  state_nxt = S_PRINT;
                  idx_nxt   = idx_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PRINT: begin
        if (can_emit) begin
          rd_en        = 1'b1;
          res_vld_nxt  = 1'b1;
          res_mem_nxt  = 1'b1;
          res_last_nxt = (idx_r == last_idx);
          if (idx_r == last_idx) begin
            cmd_pop   = 1'b1;
            state_nxt = S_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      flag_r    <= 1'b0;
      idx_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      flag_r    <= flag_nxt;
      idx_r     <= idx_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    res_mem_r    <= res_mem_nxt;
  end

  // ring store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign res.vld         = res_vld_r;
  assign res.item.status = res_status_r;
  assign res.item.data   = res_mem_r ? rd_data_r : '0;
  assign res.item.last   = res_last_r;

endmodule

// File: src/rdq_outq.sv
// Result queue between the back end and the result ports.
// Depends on rdq_pkg.
module rdq_outq #(
  parameter int OQ_DEPTH = rdq_pkg::RDQ_OQ_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rdq_pkg::rdq_res_t               res,
  output logic [$clog2(OQ_DEPTH+1)-1:0]   oq_count,
  output logic                            out_empty,
  input  logic                            out_pop,
  output rdq_pkg::rdq_out_t               out_item
);
  import rdq_pkg::*;

  localparam int PW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int CW = $clog2(OQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(OQ_DEPTH - 1);

  rdq_out_t      q_r [OQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_en;

  assign out_empty = (cnt_r == '0);
  assign rd_en     = out_pop && !out_empty;
  assign out_item  = q_r[rd_ptr_r];
  assign oq_count  = cnt_r;

  always_comb begin
    wr_ptr_nxt = res.vld ? ((wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ((rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(res.vld) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      q_r[wr_ptr_r] <= res.item;
    end
  end

endmodule

// File: src/reversible_deque.sv
// reversible_deque top level: front end, back end and result queue; uses rdq_pkg.
// Throughput: one operation per cycle while the result queue has room and no
// print is being walked; a print reads its live entries in turn through the
// single read port of the ring store.
// Reset (synchronous, rst_n low): queues empty, deque empty, reverse flag clear;
// the ring store is not cleared and needs no clearing pass.
`include "reversible_deque_defines.svh"

module reversible_deque #(
  parameter int DEPTH    = rdq_pkg::RDQ_DEPTH,
  parameter int CQ_DEPTH = rdq_pkg::RDQ_CQ_DEPTH,
  parameter int OQ_DEPTH = rdq_pkg::RDQ_OQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rdq_pkg::rdq_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output rdq_pkg::rdq_out_t out_item
);
  import rdq_pkg::*;

  localparam int QCW = $clog2(OQ_DEPTH + 1);

  // Command path: the front end decodes each transfer into a command kind and a
  // logical end, and holds it in a short queue. The physical end is resolved
  // in the back end, since a queued reverse changes it.
  logic     cmd_vld;
  rdq_cmd_t cmd;
  logic     cmd_pop;

  // Result path: the back end registers each result, then drops it into the
  // result queue. It only issues when the queue has room for the new result on
  // top of the one already in its result stage.
  rdq_res_t       res;
  logic [QCW-1:0] oq_count;

  rdq_front #(
    .CQ_DEPTH (CQ_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  // Execute pushes, pops, reverses and peeks from idle. Walk a print one entry
  // per cycle while the result queue has room; retire it with the last entry.
  rdq_back #(
    .DEPTH    (DEPTH),
    .OQ_DEPTH (OQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .oq_count (oq_count),
    .res      (res)
  );

  rdq_outq #(
    .OQ_DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .oq_count  (oq_count),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // A result must never land in a full result queue.
  `RDQ_ASSERT_IMP(a_no_res_overflow, res.vld, oq_count < QCW'(OQ_DEPTH))
  // The back end retires only commands that are present.
  `RDQ_ASSERT_IMP(a_pop_needs_cmd, cmd_pop, cmd_vld)
  // Data is nonzero only on a valid-status result.
  `RDQ_ASSERT_IMP(a_status_data, res.vld && res.item.status != ST_OK, res.item.data == '0)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for reversible_deque: random and directed deque operations,
// results predicted in-line and compared field by field. Depends on rdq_pkg and the RTL.
module tb_top;
  import rdq_pkg::*;

  localparam int RING_SLOTS = RDQ_DEPTH;

  // Every input of the block starts out at a known value.
  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     in_push = 1'b0;
  rdq_in_t  in_item = '0;
  logic     out_pop = 1'b0;
  logic     in_full;
  logic     out_empty;
  rdq_out_t out_item;

  // Idle rates in percent; the pressure test can also freeze the receiver outright.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_frozen   = 1'b0;
  int   err_count   = 0;

  // Shadow copy of the deque: ring store, head slot, live count, reverse flag.
  logic signed [31:0] ring [RING_SLOTS];
  logic [5:0]         ring_head  = '0;
  int unsigned        ring_count = 0;
  logic               ring_rev   = 1'b0;

  // Results still owed by the block, oldest first.
  rdq_out_t pending_results[$];
  rdq_out_t want;

  // Steers the random traffic toward full or toward empty.
  logic fill_dir_up = 1'b1;

  reversible_deque uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void owe_result(logic [1:0] status, logic signed [31:0] data,
                                     logic last);
    rdq_out_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    pending_results = {pending_results, r};
  endfunction

  // Apply one accepted operation to the shadow deque and queue what it must answer.
  // The reverse flag swaps which physical end the logical front refers to.
  function automatic void predict_deque_op(logic [2:0] op, logic signed [31:0] word);
    logic        phys_front;
    int unsigned off;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        phys_front = (op == OP_PUSH_FRONT) ^ ring_rev;
        if (ring_count >= RING_SLOTS) begin
          // Full: drop the word and flag it.
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          if (phys_front) begin
            ring_head       = ring_head - 6'd1;
            ring[ring_head] = word;
          end else begin
            ring[6'(ring_head + ring_count)] = word;
          end
          ring_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        phys_front = (op == OP_POP_FRONT) ^ ring_rev;
        if (ring_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (phys_front) ring_head = ring_head + 6'd1;
          ring_count--;
        end
      end
      OP_REVERSE: ring_rev = ~ring_rev;
      OP_FRONT, OP_BACK: begin
        phys_front = (op == OP_FRONT) ^ ring_rev;
        if (ring_count == 0) owe_result(ST_EMPTY, '0, 1'b1);
        else if (phys_front) owe_result(ST_OK, ring[ring_head], 1'b1);
        else owe_result(ST_OK, ring[6'(ring_head + ring_count - 1)], 1'b1);
      end
      default: begin
        // Print: one result per live entry in logical order, last flag on the final one.
        if (ring_count == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < ring_count; i++) begin
            off = ring_rev ? ring_count - 1 - i : i;
            owe_result(ST_OK, ring[6'(ring_head + off)], i + 1 == ring_count);
          end
        end
      end
    endcase
  endfunction

  // Receiver: drop pop at random, or hold it low for the whole freeze.
  always @(posedge clk) begin
    if (!rst_n || rx_frozen) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Check each result transfer against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data %0d last %0d",
               out_item.status, out_item.data, out_item.last);
        err_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_item.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_item.status);
          err_count++;
        end
        if (out_item.data !== want.data) begin
          $error("data mismatch: expected %0d, actual %0d", want.data, out_item.data);
          err_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_item.last);
          err_count++;
        end
      end
    end
  end

  // Offer one operation after a random idle stretch; hold it until the transfer,
  // then advance the shadow deque. Push stays high when the next item follows at once.
  task automatic send_op(input logic [2:0] op, input logic signed [31:0] word);
    rdq_in_t offer;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    offer.op    = op;
    offer.value = word;
    in_push <= 1'b1;
    in_item <= offer;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_deque_op(op, word);
  endtask

  // Mostly full-range random words, now and then an extreme.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Wait until every owed result is in, then let the pipeline settle.
  task automatic wait_drain();
    int unsigned waited;
    waited = 0;
    while (pending_results.size() != 0 && waited < 50_000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Every operation that can fail on an empty deque.
  task automatic test_empty_cases();
    send_op(OP_PRINT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_FRONT, '0);
    send_op(OP_BACK, 32'sh7fff_ffff);
  endtask

  // Extreme words at both ends, then peek and print them back.
  task automatic test_push_peek_print();
    send_op(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(OP_PUSH_BACK, 32'sh8000_0000);
    send_op(OP_PUSH_FRONT, -32'sd1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_FRONT, '0);
    send_op(OP_BACK, '0);
    send_op(OP_PRINT, -32'sd1);
  endtask

  // Flip the ends, push and pop through the flipped view, flip back.
  task automatic test_reverse();
    send_op(OP_REVERSE, '0);
    send_op(OP_FRONT, '0);
    send_op(OP_BACK, '0);
    send_op(OP_PRINT, '0);
    send_op(OP_PUSH_FRONT, 32'sd1);
    send_op(OP_PUSH_BACK, 32'sd2);
    send_op(OP_PRINT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REVERSE, '0);
    send_op(OP_PRINT, '0);
  endtask

  // Freeze the receiver for a long stretch while the sender fills the deque,
  // overfills it and asks for peeks and full prints; the input must stall.
  task automatic test_backpressure();
    rx_frozen <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_frozen <= 1'b0;
      end
    join_none
    while (ring_count < RING_SLOTS)
      send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    send_op(OP_PUSH_BACK, pick_word());
    send_op(OP_PUSH_FRONT, pick_word());
    send_op(OP_FRONT, '0);
    send_op(OP_BACK, '0);
    send_op(OP_PRINT, '0);
    send_op(OP_REVERSE, '0);
    send_op(OP_PUSH_FRONT, pick_word());
    send_op(OP_PRINT, '0);
    send_op(OP_FRONT, '0);
    fill_dir_up = 1'b0;
  endtask

  // Random traffic that drifts between empty and full, so both limits are hit
  // with random contents; peeks, reverses and prints are mixed in throughout.
  task automatic test_random_traffic(input int n_items);
    int unsigned pick;
    logic [2:0]  op;
    for (int n = 0; n < n_items; n++) begin
      if (ring_count == RING_SLOTS) fill_dir_up = 1'b0;
      else if (ring_count == 0) fill_dir_up = 1'b1;
      else if ($urandom_range(0, 99) < 3) fill_dir_up = ~fill_dir_up;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_PRINT;
      else if (pick < 10) op = OP_REVERSE;
      else if (pick < 22) op = $urandom_range(0, 1) ? OP_FRONT : OP_BACK;
      else if ($urandom_range(0, 99) < (fill_dir_up ? 75 : 25))
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      send_op(op, pick_word());
    end
  endtask

  initial begin
    // Hold reset at the start, once.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender mostly busy, receiver mostly idle.
    tx_idle_pct = 23;
    rx_idle_pct = 71;
    test_empty_cases();
    test_push_peek_print();
    test_reverse();
    test_random_traffic(140);

    // Sender mostly idle, receiver mostly busy.
    tx_idle_pct = 71;
    rx_idle_pct = 23;
    test_random_traffic(140);

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_traffic(110);

    // Drop push right at the last transfer so the final item goes in only once.
    in_push <= 1'b0;
    wait_drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
